### design/urn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urn_pkg: shared types and helpers for the URI percent renormalizer
// Item structs, the decoded-entry format and the character class helpers.
// ----------------------------------------------------------------------------
package urn_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int MAX_DEC = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]              cnt;
    logic                    last;
    logic [MAX_DEC-1:0][7:0] data;
  } dec_entry_t;

  typedef struct packed {
    logic       valid;
    dec_entry_t entry;
  } q_head_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) v = c[3:0];
    else if (((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66)))
      v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_DASH) || (c == CH_DOT) ||
           (c == CH_UNDER) || (c == CH_TILDE);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) r = 8'h30 + {4'd0, n};
    else r = 8'h37 + {4'd0, n};
    return r;
  endfunction

endpackage
`default_nettype wire

### design/urn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urn_front: percent decoder
// Accepts raw bytes, holds escape lookahead and emits at most one decoded
// entry of up to three bytes per input item.
// ----------------------------------------------------------------------------
module urn_front import urn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire in_item_t   item,
  output logic            push,
  output dec_entry_t      entry
);

  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic [7:0] held_digit_r, held_digit_nxt;
  logic [1:0] k;
  logic       b_hex;
  logic [7:0] b;

  assign b     = item.in_byte;
  assign b_hex = is_hex(b);

  always_comb begin
    held_cnt_nxt   = held_cnt_r;
    held_digit_nxt = held_digit_r;
    entry          = '0;
    k              = 2'd0;
    unique case (held_cnt_r)
      2'd1: begin
        if (b_hex) begin
          held_cnt_nxt   = 2'd2;
          held_digit_nxt = b;
        end else begin
          entry.data[k] = CH_PCT;
          k = k + 2'd1;
          if (b == CH_PCT) held_cnt_nxt = 2'd1;
          else begin
            held_cnt_nxt  = 2'd0;
            entry.data[k] = b;
            k = k + 2'd1;
          end
        end
      end
      2'd2: begin
        if (b_hex) begin
          entry.data[k] = {hex_val(held_digit_r), hex_val(b)};
          k = k + 2'd1;
          held_cnt_nxt = 2'd0;
        end else begin
          entry.data[k] = CH_PCT;
          k = k + 2'd1;
          entry.data[k] = held_digit_r;
          k = k + 2'd1;
          if (b == CH_PCT) held_cnt_nxt = 2'd1;
          else begin
            held_cnt_nxt  = 2'd0;
            entry.data[k] = b;
            k = k + 2'd1;
          end
        end
      end
      default: begin
        if (b == CH_PCT) held_cnt_nxt = 2'd1;
        else begin
          held_cnt_nxt  = 2'd0;
          entry.data[k] = b;
          k = k + 2'd1;
        end
      end
    endcase
    if (item.in_last) begin
      if (held_cnt_nxt == 2'd1) begin
        entry.data[k] = CH_PCT;
        k = k + 2'd1;
      end else if (held_cnt_nxt == 2'd2) begin
        entry.data[k] = CH_PCT;
        k = k + 2'd1;
        entry.data[k] = held_digit_nxt;
        k = k + 2'd1;
      end
      held_cnt_nxt = 2'd0;
    end
    entry.cnt  = k;
    entry.last = item.in_last;
  end

  assign push = accept && (k != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r   <= 2'd0;
      held_digit_r <= 8'd0;
    end else if (accept) begin
      held_cnt_r   <= held_cnt_nxt;
      held_digit_r <= held_digit_nxt;
    end
  end

endmodule
`default_nettype wire

### design/urn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urn_queue: decoded entry queue
// Short FIFO between decoder and encoder so each side stalls on its own.
// ----------------------------------------------------------------------------
module urn_queue import urn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire dec_entry_t wr_entry,
  input  wire logic       pop,
  output q_head_t         head,
  output logic            full
);

  dec_entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;

  assign full        = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid  = (cnt_r != '0);
  assign head.entry  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule
`default_nettype wire

### design/urn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urn_back: percent encoder
// Walks each decoded entry and emits one output character per cycle into a
// registered output stage, unless the output stalls or no entry waits.
// ----------------------------------------------------------------------------
module urn_back import urn_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    slash_mode,
  input  wire q_head_t head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_data
);

  logic [1:0] bi_r, bi_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;
  logic [7:0] c;
  logic [7:0] ch;
  logic       esc;
  logic       load;
  logic       byte_end;
  logic       ent_end;

  assign c        = head.entry.data[bi_r];
  assign esc      = !(is_unreserved(c) || ((c == CH_SLASH) && !slash_mode));
  assign load     = head.valid && (!out_valid_r || !out_stall);
  assign byte_end = !esc || (ph_r == 2'd2);
  assign ent_end  = byte_end && (bi_r == (head.entry.cnt - 2'd1));
  assign pop      = load && ent_end;

  always_comb begin
    unique case (ph_r)
      2'd0:    ch = esc ? CH_PCT : c;
      2'd1:    ch = hex_char(c[7:4]);
      default: ch = hex_char(c[3:0]);
    endcase
  end

  always_comb begin
    bi_nxt = bi_r;
    ph_nxt = ph_r;
    if (load) begin
      if (byte_end) begin
        ph_nxt = 2'd0;
        bi_nxt = ent_end ? 2'd0 : bi_r + 2'd1;
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
    if (load) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bi_r        <= 2'd0;
      ph_r        <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      bi_r        <= bi_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_char <= ch;
      out_data_r.out_last <= head.entry.last && ent_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### design/uri_percent_renormalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uri_percent_renormalizer_top: streaming URI percent renormalizer
// Input channel (in_valid/in_stall/in_data) takes one raw byte per item with
// a last flag. The decoder resolves %XY escapes and keeps up to two bytes of
// lookahead, flushing them on the last byte. Decoded bytes queue up (two
// entries) for the encoder, which emits one character per cycle on the
// output channel (out_valid/out_stall/out_data): unreserved characters and,
// unless cfg_data turned slash escaping on, '/' pass; anything else is %XY.
// With queue and output stage empty, an accepted item's entry is written to
// the queue, then its first character is registered into the output stage.
// The decoder takes one input item per cycle while the queue is not full; the
// encoder emits one character per cycle while the output is not stalled, and
// an item yields up to 7 characters, typically 1 or 3. in_stall rises only
// while the queue is full. A stalled output holds its character while the
// encoder waits. Reset clears held lookahead, the queue and the output stage
// and turns slash escaping off. Write cfg only when idle.
// ----------------------------------------------------------------------------
module uri_percent_renormalizer_top import urn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic       slash_mode_r;
  logic       accept;
  logic       push;
  logic       pop;
  logic       q_full;
  dec_entry_t dec_entry;
  q_head_t    head;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) slash_mode_r <= 1'b0;
    else if (cfg_we) slash_mode_r <= cfg_data;
  end

  urn_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .push   (push),
    .entry  (dec_entry)
  );

  urn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (dec_entry),
    .pop      (pop),
    .head     (head),
    .full     (q_full)
  );

  urn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .slash_mode (slash_mode_r),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

### verif/uri_percent_renormalizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_percent_renormalizer_top_test: self-checking bench for the renormalizer
// Byte strings go in as items in random bursts. A short directed set of
// escapes, broken escapes and dangling lookahead comes first, then mostly
// well-formed random strings with some noise. The output is stalled on a
// rotating pattern. Every output character is predicted from a local
// decode/re-encode model and checked in order, over both slash settings.
// ----------------------------------------------------------------------------
module uri_percent_renormalizer_top_test import urn_pkg::*;;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_LZ   = 8'h7A;

  localparam logic [127:0] HEX_UPPER = "0123456789ABCDEF";
  localparam int           MAX_OUT      = 7;
  localparam int           DRAIN_CYCLES = 8;
  localparam int           PHASE_BYTES  = 70;
  localparam int           NUM_PHASES   = 6;
  localparam logic [5:0]   SLASH_PLAN   = 6'b101101;
  localparam int           LIMIT_NS     = 1000000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  in_item_t   raw_bytes[$];
  out_item_t  expected_chars[$];
  logic [7:0] decoded[$];

  logic [1:0] held_cnt   = 2'd0;
  logic [7:0] held_digit = 8'h00;
  logic       slash_enc  = 1'b0;

  int mismatches = 0;
  int burst_left = 0;
  int gap_left   = 0;
  logic [31:0] stall_pat = 32'h0;
  int pat_age = 0;

  uri_percent_renormalizer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  function automatic logic passes_plain(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_DOT ||
           c == CH_UNDER || c == CH_TILDE;
  endfunction

  function automatic logic [7:0] hex_upper_char(logic [3:0] n);
    return HEX_UPPER[(15 - int'(n)) * 8 +: 8];
  endfunction

  function automatic void take_fresh(logic [7:0] b);
    if (b == CH_PCT) begin
      held_cnt = 2'd1;
    end else begin
      held_cnt = 2'd0;
      decoded = {decoded, b};
    end
  endfunction

  function automatic void renormalize_item(in_item_t it);
    logic [7:0] c;
    logic [7:0] enc[$];
    out_item_t  o;
    int lo;
    int hi;
    lo = hex_nibble(it.in_byte);
    decoded.delete();
    if (held_cnt == 2'd3) held_cnt = 2'd0;
    case (held_cnt)
      2'd1: begin
        if (lo >= 0) begin
          held_cnt   = 2'd2;
          held_digit = it.in_byte;
        end else begin
          decoded = {decoded, CH_PCT};
          take_fresh(it.in_byte);
        end
      end
      2'd2: begin
        if (lo >= 0) begin
          hi = hex_nibble(held_digit);
          if (hi < 0) hi = 0;
          decoded = {decoded, 8'((hi << 4) | lo)};
          held_cnt = 2'd0;
        end else begin
          decoded = {decoded, CH_PCT, held_digit};
          take_fresh(it.in_byte);
        end
      end
      default: take_fresh(it.in_byte);
    endcase
    if (it.in_last) begin
      if (held_cnt != 2'd0) decoded = {decoded, CH_PCT};
      if (held_cnt == 2'd2) decoded = {decoded, held_digit};
      held_cnt = 2'd0;
    end
    foreach (decoded[i]) begin
      c = decoded[i];
      if (passes_plain(c) || (c == CH_SLASH && !slash_enc)) begin
        if (enc.size() < MAX_OUT) enc = {enc, c};
      end else if (enc.size() + 3 <= MAX_OUT) begin
        enc = {enc, CH_PCT, hex_upper_char(c[7:4]), hex_upper_char(c[3:0])};
      end
    end
    foreach (enc[i]) begin
      o.out_char = enc[i];
      o.out_last = it.in_last && (i == enc.size() - 1);
      expected_chars = {expected_chars, o};
    end
  endfunction

  task automatic flag_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void push_byte(logic [7:0] b, logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    raw_bytes = {raw_bytes, it};
  endfunction

  function automatic void push_string(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_plain();
    case ($urandom_range(0, 3))
      0: return CH_ZERO + 8'($urandom_range(0, 9));
      1: return CH_UA + 8'($urandom_range(0, 25));
      2: return CH_LA + 8'($urandom_range(0, 25));
      default: begin
        case ($urandom_range(0, 3))
          0: return CH_DASH;
          1: return CH_DOT;
          2: return CH_UNDER;
          default: return CH_TILDE;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_hex();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) return CH_ZERO + v;
    return (($urandom_range(0, 1) == 0) ? CH_UA : CH_LA) + v - 8'd10;
  endfunction

  function automatic int push_random_string();
    logic [7:0] s[$];
    int len;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: s = {s, rand_plain()};
        8, 9: s = {s, CH_SLASH};
        10, 11, 12, 13, 14: s = {s, CH_PCT, rand_hex(), rand_hex()};
        15, 16: s = {s, 8'($urandom_range(0, 255))};
        17: s = {s, CH_PCT};
        default: s = {s, CH_PCT, rand_hex(), 8'($urandom_range(0, 255))};
      endcase
    end
    foreach (s[i]) push_byte(s[i], i == s.size() - 1);
    return s.size();
  endfunction

  task automatic wait_idle();
    while (raw_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slash_mode(logic v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slash_enc = v;
  endtask

  always @(posedge clk) begin : drive
    logic fire;
    logic show;
    fire = in_valid && !in_stall;
    show = in_valid && !fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        renormalize_item(in_data);
        void'(raw_bytes.pop_front());
      end
      if (!show) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (raw_bytes.size() != 0) begin
          show = 1'b1;
          in_data <= raw_bytes[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= show;
    end
  end

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %02h last %0b",
                                out_data.out_char, out_data.out_last));
      end else begin
        want = expected_chars.pop_front();
        if (out_data.out_char !== want.out_char)
          flag_mismatch($sformatf("out_char %02h, want %02h",
                                  out_data.out_char, want.out_char));
        if (out_data.out_last !== want.out_last)
          flag_mismatch($sformatf("out_last %0b, want %0b on char %02h",
                                  out_data.out_last, want.out_last, want.out_char));
      end
    end
    if (pat_age == 0) begin
      pat_age = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: stall_pat = 32'h0;
        1: stall_pat = $urandom & $urandom & $urandom;
        2: stall_pat = $urandom;
        default: stall_pat = $urandom | $urandom;
      endcase
    end else begin
      pat_age--;
    end
    stall_pat = {stall_pat[30:0], stall_pat[31]};
    out_stall <= stall_pat[0];
  end

  initial begin : limit
    #LIMIT_NS;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    int made;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_slash_mode(1'b0);

    // escapes at end, broken escapes, dangling lookahead, byte extremes
    push_string("%2f");
    push_string("%4%");
    push_string("%%41");
    push_string("%4G");
    push_string("%F");
    push_string("%");
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_string("a/~");

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_slash_mode(SLASH_PLAN[p]);
      made = 0;
      while (made < PHASE_BYTES) made += push_random_string();
    end
    wait_idle();

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
design/urn_pkg.sv
design/urn_front.sv
design/urn_queue.sv
design/urn_back.sv
design/uri_percent_renormalizer_top.sv
verif/uri_percent_renormalizer_top_test.sv
